// ===== src/serial_date_week_number_top_assert.svh =====
// Assertion macros used by the checker file of the week-number block.
`ifndef SERIAL_DATE_WEEK_NUMBER_TOP_ASSERT_SVH
`define SERIAL_DATE_WEEK_NUMBER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define SWN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define SWN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/swn_pkg.sv =====
// Types, constants and helper functions of the week-number block.
package swn_pkg;

	localparam int unsigned NUM_STAGES = 11;
	localparam int unsigned CIV_STAGES = 7;

	localparam logic [21:0] SERIAL_MAX = 22'd2958465;
	localparam logic [21:0] BUG_OFFSET = 22'd58;
	localparam logic [21:0] DAY0_Z     = 22'd693901;
	localparam logic [13:0] YEAR_BASE  = 14'd1900;
	localparam logic [13:0] ERA_YEARS  = 14'd400;

	localparam logic [17:0] DAYS_ERA   = 18'd146097;
	localparam logic [17:0] ERA_LAST   = 18'd146096;
	localparam logic [17:0] CENT_1     = 18'd36524;
	localparam logic [17:0] CENT_2     = 18'd73048;
	localparam logic [17:0] CENT_3     = 18'd109572;
	localparam logic [17:0] YEAR_DAYS  = 18'd365;

	localparam logic [8:0] MAR_JAN     = 9'd306;  // Jan 1 in a March-based year
	localparam logic [8:0] JAN_ADJ     = 9'd305;
	localparam logic [8:0] MAR_ADJ     = 9'd60;

	// week numbering codes
	localparam logic [7:0] CODE_SUN     = 8'd1;
	localparam logic [7:0] CODE_MON     = 8'd2;
	localparam logic [7:0] CODE_MON_ALT = 8'd11;
	localparam logic [7:0] CODE_TUE     = 8'd12;
	localparam logic [7:0] CODE_WED     = 8'd13;
	localparam logic [7:0] CODE_THU     = 8'd14;
	localparam logic [7:0] CODE_FRI     = 8'd15;
	localparam logic [7:0] CODE_SAT     = 8'd16;
	localparam logic [7:0] CODE_SUN_ALT = 8'd17;
	localparam logic [7:0] ISO_CODE     = 8'd21;
	localparam logic [7:0] CODE_DAY_OFS = 8'd10;

	// ISO weekdays
	localparam logic [2:0] WD_NONE = 3'd0;
	localparam logic [2:0] WD_MON  = 3'd1;
	localparam logic [2:0] WD_WED  = 3'd3;
	localparam logic [2:0] WD_THU  = 3'd4;
	localparam logic [2:0] WD_SUN  = 3'd7;
	localparam logic [3:0] WEEK_DAYS = 4'd7;

	localparam logic [5:0] ZERO_ISO_WEEK = 6'd52;
	localparam logic [5:0] WEEKS_SHORT   = 6'd52;
	localparam logic [5:0] WEEKS_LONG    = 6'd53;
	localparam logic [5:0] WEEK_MAX      = 6'd54;

	// reciprocals: m = ceil(2^k / d), k = bits(n) + ceil(log2 d), exact for all n
	localparam int unsigned ERA_SH = 40;
	localparam int unsigned W7_SH  = 25;
	localparam int unsigned C_SH   = 29;
	localparam int unsigned Y_SH   = 27;
	localparam int unsigned D7_SH  = 12;
	localparam logic [22:0] REC_ERA = 23'(((64'd1 << ERA_SH) + 64'd146097 - 64'd1) / 64'd146097);
	localparam logic [22:0] REC_W7  = 23'(((64'd1 << W7_SH) + 64'd7 - 64'd1) / 64'd7);
	localparam logic [18:0] REC_C   = 19'(((64'd1 << C_SH) + 64'd1460 - 64'd1) / 64'd1460);
	localparam logic [18:0] REC_Y   = 19'(((64'd1 << Y_SH) + 64'd365 - 64'd1) / 64'd365);
	localparam logic [9:0]  REC_D7  = 10'(((64'd1 << D7_SH) + 64'd7 - 64'd1) / 64'd7);

	typedef struct packed {
		logic [21:0] serial_day;
		logic [7:0]  week_system;
	} swn_req_t;

	typedef struct packed {
		logic [5:0] week_num;
		logic       error;
	} swn_rsp_t;

	typedef struct packed {
		logic       bad;
		logic       zero;
		logic       iso;
		logic [2:0] sday;
	} swn_ctl_t;

	// year split inside a 400-year era, March-based
	typedef struct packed {
		swn_ctl_t   ctl;
		logic [4:0] era;
		logic [8:0] yoe;
		logic [8:0] dy;
		logic [2:0] wday;
	} swn_civ_t;

	typedef logic [NUM_STAGES-1:0] swn_en_t;

	function automatic logic [2:0] start_day(input logic [7:0] code);
		logic [2:0] sd;
		unique case (code)
			CODE_SUN, CODE_SUN_ALT: sd = WD_SUN;
			CODE_MON, CODE_MON_ALT: sd = WD_MON;
			CODE_TUE, CODE_WED, CODE_THU, CODE_FRI, CODE_SAT: sd = 3'(code - CODE_DAY_OFS);
			default: sd = WD_NONE;
		endcase
		return sd;
	endfunction

	// leap test on the year within its era, 0..400
	function automatic logic leap_in_era(input logic [8:0] c);
		return (c[1:0] == 2'b00) && (c != 9'd100) && (c != 9'd200) && (c != 9'd300);
	endfunction

endpackage

// ===== src/swn_pipe_ctrl.sv =====
// Valid bits and stall chain of the week-number pipeline.
module swn_pipe_ctrl import swn_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	output logic    rsp_valid,
	input  logic    rsp_stall,
	output swn_en_t en
);

	logic [NUM_STAGES-1:0] stage_vld_q;
	logic [NUM_STAGES-1:0] vld_in;
	logic [NUM_STAGES-1:0] rdy;

	assign vld_in = {stage_vld_q[NUM_STAGES-2:0], req_valid};

	// a stage loads when empty or when the one after it moves
	always_comb begin
		rdy[NUM_STAGES-1] = !stage_vld_q[NUM_STAGES-1] || !rsp_stall;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			rdy[i] = !stage_vld_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int i = 0; i < NUM_STAGES; i++) begin
				if (rdy[i]) begin
					stage_vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	assign en        = rdy;
	assign req_stall = !rdy[0];
	assign rsp_valid = stage_vld_q[NUM_STAGES-1];

endmodule

// ===== src/swn_civil.sv =====
// Stages 1-7: code decode, serial to day index, era and year-of-era split, weekday.
module swn_civil import swn_pkg::*; (
	input  logic                  clk,
	input  logic [CIV_STAGES-1:0] en,
	input  swn_req_t              req,
	output swn_civ_t              civ
);

	// stage 1
	swn_ctl_t    ctl_c;
	logic [21:0] off_c, off_fix_c, z_c;
	swn_ctl_t    ctl_s1;
	logic [21:0] z_s1;

	always_comb begin
		ctl_c.sday = start_day(req.week_system);
		ctl_c.iso  = (req.week_system == ISO_CODE);
		ctl_c.zero = (req.serial_day == '0);
		ctl_c.bad  = ((ctl_c.sday == WD_NONE) && !ctl_c.iso) || (req.serial_day > SERIAL_MAX);
		off_c      = req.serial_day - 22'd1;
		// the phantom Feb 29 1900 folds onto Feb 28
		off_fix_c  = (off_c > BUG_OFFSET) ? off_c - 22'd1 : off_c;
		z_c        = DAY0_Z + off_fix_c;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ctl_s1 <= ctl_c;
			z_s1   <= z_c;
		end
	end

	// stage 2: era and day/7 quotients
	logic [44:0] era_prod_c, w7_prod_c;
	logic [21:0] zp2_c;
	swn_ctl_t    ctl_s2;
	logic [21:0] z_s2, zp2_s2;
	logic [4:0]  era_s2;
	logic [19:0] q7_s2;

	always_comb begin
		zp2_c      = z_s1 + 22'd2;
		era_prod_c = 45'(z_s1) * 45'(REC_ERA);
		w7_prod_c  = 45'(zp2_c) * 45'(REC_W7);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ctl_s2 <= ctl_s1;
			z_s2   <= z_s1;
			zp2_s2 <= zp2_c;
			era_s2 <= era_prod_c[44:40];
			q7_s2  <= w7_prod_c[44:25];
		end
	end

	// stage 3: day of era, weekday
	logic [21:0] era_mul_c, w_mul_c, w_rem_c;
	swn_ctl_t    ctl_s3;
	logic [17:0] doe_s3;
	logic [4:0]  era_s3;
	logic [2:0]  wday_s3;

	always_comb begin
		era_mul_c = 22'(era_s2) * 22'(DAYS_ERA);
		w_mul_c   = 22'(q7_s2) * 22'(WEEK_DAYS);
		w_rem_c   = zp2_s2 - w_mul_c;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ctl_s3  <= ctl_s2;
			doe_s3  <= 18'(z_s2 - era_mul_c);
			era_s3  <= era_s2;
			wday_s3 <= w_rem_c[2:0] + 3'd1;
		end
	end

	// stage 4: leap-cycle corrections
	logic [36:0] c_prod_c;
	logic [1:0]  q2_c;
	swn_ctl_t    ctl_s4;
	logic [17:0] doe_s4;
	logic [4:0]  era_s4;
	logic [2:0]  wday_s4;
	logic [6:0]  q1_s4;
	logic [1:0]  q2_s4;
	logic        q3_s4;

	always_comb begin
		c_prod_c = 37'(doe_s3) * 37'(REC_C);
		q2_c     = 2'({1'b0, doe_s3 >= CENT_1}) + 2'({1'b0, doe_s3 >= CENT_2})
		         + 2'({1'b0, doe_s3 >= CENT_3});
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			ctl_s4  <= ctl_s3;
			doe_s4  <= doe_s3;
			era_s4  <= era_s3;
			wday_s4 <= wday_s3;
			q1_s4   <= c_prod_c[35:29];
			q2_s4   <= q2_c;
			q3_s4   <= (doe_s3 == ERA_LAST);
		end
	end

	// stage 5
	swn_ctl_t    ctl_s5;
	logic [17:0] doe_s5, t_s5;
	logic [4:0]  era_s5;
	logic [2:0]  wday_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			ctl_s5  <= ctl_s4;
			doe_s5  <= doe_s4;
			era_s5  <= era_s4;
			wday_s5 <= wday_s4;
			t_s5    <= doe_s4 - 18'(q1_s4) + 18'(q2_s4) - 18'(q3_s4);
		end
	end

	// stage 6: year of era
	logic [36:0] y_prod_c;
	swn_ctl_t    ctl_s6;
	logic [17:0] doe_s6;
	logic [4:0]  era_s6;
	logic [2:0]  wday_s6;
	logic [8:0]  yoe_s6;

	assign y_prod_c = 37'(t_s5) * 37'(REC_Y);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			ctl_s6  <= ctl_s5;
			doe_s6  <= doe_s5;
			era_s6  <= era_s5;
			wday_s6 <= wday_s5;
			yoe_s6  <= y_prod_c[35:27];
		end
	end

	// stage 7: day within the March-based year
	logic [1:0]  cent_c;
	logic [17:0] base_c;
	swn_civ_t    civ_s7;

	always_comb begin
		cent_c = 2'({1'b0, yoe_s6 >= 9'd100}) + 2'({1'b0, yoe_s6 >= 9'd200})
		       + 2'({1'b0, yoe_s6 >= 9'd300});
		base_c = 18'(yoe_s6) * YEAR_DAYS + 18'(yoe_s6 >> 2) - 18'(cent_c);
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			civ_s7.ctl  <= ctl_s6;
			civ_s7.era  <= era_s6;
			civ_s7.yoe  <= yoe_s6;
			civ_s7.wday <= wday_s6;
			civ_s7.dy   <= 9'(doe_s6 - base_c);
		end
	end

	assign civ = civ_s7;

endmodule

// ===== src/swn_week.sv =====
// Stages 8-11: day of year, Jan 1 weekday, week count and result selection.
module swn_week import swn_pkg::*; (
	input  logic                             clk,
	input  logic [NUM_STAGES-CIV_STAGES-1:0] en,
	input  swn_civ_t                         civ,
	output swn_rsp_t                         rsp
);

	// stage 8: calendar year, leap flags, day of year
	logic        jf_c, leap_c, leapp_c;
	logic [8:0]  c_c, doy_c;
	logic [13:0] year_c;
	swn_ctl_t    ctl_s8;
	logic [8:0]  doy_s8;
	logic        leap_s8, leapp_s8, base_s8;
	logic [2:0]  wday_s8;

	always_comb begin
		jf_c    = (civ.dy >= MAR_JAN);
		c_c     = civ.yoe + 9'(jf_c);
		leap_c  = leap_in_era(c_c);
		// year zero of an era follows year 399 of the last one, never leap
		leapp_c = (c_c != '0) && leap_in_era(c_c - 9'd1);
		doy_c   = jf_c ? civ.dy - JAN_ADJ : civ.dy + MAR_ADJ + 9'(leap_c);
		year_c  = 14'(civ.era) * ERA_YEARS + 14'(c_c);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ctl_s8   <= civ.ctl;
			doy_s8   <= doy_c;
			leap_s8  <= leap_c;
			leapp_s8 <= leapp_c;
			base_s8  <= (year_c == YEAR_BASE);
			wday_s8  <= civ.wday;
		end
	end

	// stage 9: weekday of Jan 1
	logic [8:0]  dn_c;
	logic [18:0] dq_prod_c;
	logic [8:0]  dq_mul_c;
	logic [2:0]  dm_c, j1_c;
	swn_ctl_t    ctl_s9;
	logic [8:0]  doy_s9;
	logic        leap_s9, leapp_s9, base_s9;
	logic [2:0]  wday_s9, j1_s9;

	always_comb begin
		dn_c      = doy_s8 - 9'd1;
		dq_prod_c = 19'(dn_c) * 19'(REC_D7);
		dq_mul_c  = 9'(dq_prod_c[17:12]) * 9'(WEEK_DAYS);
		dm_c      = 3'(dn_c - dq_mul_c);
		j1_c      = (wday_s8 > dm_c) ? wday_s8 - dm_c
		                             : 3'(4'(wday_s8) + WEEK_DAYS - 4'(dm_c));
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			ctl_s9   <= ctl_s8;
			doy_s9   <= doy_s8;
			leap_s9  <= leap_s8;
			leapp_s9 <= leapp_s8;
			base_s9  <= base_s8;
			wday_s9  <= wday_s8;
			j1_s9    <= j1_c;
		end
	end

	// stage 10: lead days, ISO numerator, long-year flags
	logic [2:0] f_c, lead_c, sub_c, j1p_c;
	logic [8:0] iso_t_c, simple_n_c;
	swn_ctl_t   ctl_s10;
	logic [8:0] n_s10;
	logic       short_s10, cur53_s10, prev53_s10;

	always_comb begin
		// the base year starts on a Sunday for the simple systems
		f_c        = base_s9 ? WD_SUN : j1_s9;
		lead_c     = (f_c >= ctl_s9.sday) ? f_c - ctl_s9.sday
		                                  : 3'(4'(f_c) + WEEK_DAYS - 4'(ctl_s9.sday));
		simple_n_c = doy_s9 + 9'(lead_c) + 9'd6;
		iso_t_c    = doy_s9 + 9'd10 - 9'(wday_s9);
		sub_c      = 3'd1 + 3'(leapp_s9);
		j1p_c      = (j1_s9 > sub_c) ? j1_s9 - sub_c
		                             : 3'(4'(j1_s9) + WEEK_DAYS - 4'(sub_c));
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ctl_s10    <= ctl_s9;
			n_s10      <= ctl_s9.iso ? iso_t_c : simple_n_c;
			short_s10  <= (iso_t_c < 9'(WEEK_DAYS));
			cur53_s10  <= (j1_s9 == WD_THU) || ((j1_s9 == WD_WED) && leap_s9);
			prev53_s10 <= (j1p_c == WD_THU) || ((j1p_c == WD_WED) && leapp_s9);
		end
	end

	// stage 11: divide by seven, pick the result
	logic [18:0] wq_prod_c;
	logic [5:0]  wq_c, cur_wk_c, prev_wk_c;
	swn_rsp_t    rsp_c;
	swn_rsp_t    rsp_s11;

	always_comb begin
		wq_prod_c = 19'(n_s10) * 19'(REC_D7);
		wq_c      = wq_prod_c[17:12];
		cur_wk_c  = cur53_s10 ? WEEKS_LONG : WEEKS_SHORT;
		prev_wk_c = prev53_s10 ? WEEKS_LONG : WEEKS_SHORT;
		rsp_c     = '0;
		priority if (ctl_s10.bad) begin
			rsp_c.error = 1'b1;
		end else if (ctl_s10.zero) begin
			if (ctl_s10.iso) begin
				rsp_c.week_num = ZERO_ISO_WEEK;
			end else begin
				rsp_c.week_num = (ctl_s10.sday == WD_SUN) ? 6'd0 : 6'd1;
			end
		end else if (ctl_s10.iso) begin
			if (short_s10) begin
				rsp_c.week_num = prev_wk_c;
			end else begin
				rsp_c.week_num = (wq_c > cur_wk_c) ? 6'd1 : wq_c;
			end
		end else begin
			rsp_c.week_num = wq_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			rsp_s11 <= rsp_c;
		end
	end

	assign rsp = rsp_s11;

endmodule

// ===== src/serial_date_week_number_top.sv =====
// Top level of the week-of-year unit for spreadsheet day serials.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  req     | in        | req_valid/req_stall  | serial_day[22], week_system[8]
//  rsp     | out       | rsp_valid/rsp_stall  | week_num[6], error[1]
//
// One request per cycle sustained while rsp_stall is low; each result is
// presented once its request has passed the eleven register stages (era
// split, leap-cycle corrections, year-of-era multiply, Jan 1 weekday, final
// divide by seven).
// Reset clears only the stage valid bits; the datapath registers hold junk.
// A stall at the output ripples back only through full stages: bubbles are
// filled, and req_stall rises only when every stage holds a request.
module serial_date_week_number_top import swn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  swn_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output swn_rsp_t rsp
);

	swn_en_t  en;   // per-stage load enables
	swn_civ_t civ;  // year split after stage 7

	// valid bits and the back-pressure chain
	swn_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.en        (en)
	);

	// stages 1-7: decode, fold the phantom leap day, day index to era/year/day
	swn_civil u_civil (
		.clk (clk),
		.en  (en[CIV_STAGES-1:0]),
		.req (req),
		.civ (civ)
	);

	// stages 8-11: day of year, Jan 1 weekday, week count, special cases
	swn_week u_week (
		.clk (clk),
		.en  (en[NUM_STAGES-1:CIV_STAGES]),
		.civ (civ),
		.rsp (rsp)
	);

endmodule

// ===== src/swn_checker.sv =====
// Port-level checks of the week-number block and their bind.
`include "serial_date_week_number_top_assert.svh"

module swn_checker import swn_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_stall,
	input swn_req_t req,
	input logic     rsp_valid,
	input logic     rsp_stall,
	input swn_rsp_t rsp
);

	// requests back up only when the pipe is full behind a stalled result
	`SWN_ASSERT_IMP(a_stall_src, req_stall, rsp_valid && rsp_stall, "req_stall without stalled rsp")

	`SWN_ASSERT_IMP(a_err_zero, rsp_valid && rsp.error, rsp.week_num == '0, "error with nonzero week")

	`SWN_ASSERT_IMP(a_week_max, rsp_valid && !rsp.error, rsp.week_num <= WEEK_MAX, "week out of range")

	`SWN_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled rsp changed")

endmodule

bind serial_date_week_number_top swn_checker u_swn_checker (.*);
